// ----- sv/nrbp_pkg.sv -----
// Shared types and constants for the nibble run-length to bitplane decoder.
// Used by the front queue, the back decoder and the top level.
package nrbp_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned NIBBLES         = 8;
  localparam int unsigned WIDTH_W         = 12;
  localparam int unsigned MASK_W          = 16;
  localparam int unsigned COLUMN_BITS_DEF = 12;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd320;
  localparam logic [MASK_W-1:0]  MASK_RESET  = 16'h0000;

  localparam logic [WORD_W-1:0] HI_SLOT = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LO_SLOT = 32'h0000_8000;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_RLE_MASK    = 1'b1;

  typedef struct packed {
    logic [NIBBLES-1:0] run_hit;
    logic               final_word;
    logic [WORD_W-1:0]  code_word;
  } nrbp_entry_t;

endpackage

// ----- sv/nibble_rle_to_interleaved_bitplanes_unit.sv -----
// Top level of the nibble run-length decoder to interleaved bitplane words.
// Holds the configuration registers and joins nrbp_front and nrbp_back.
//
// Each 32-bit word is loaded from the queue, decoded one nibble at a time
// with an extra step for each additional run copy, and closed by the
// finish and tail states. A two-entry queue lets new words arrive while one
// is decoded, and a full output register stalls placement only when a
// finished group cannot move on.
module nibble_rle_to_interleaved_bitplanes_unit
  import nrbp_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [WORD_W-1:0]    s_axis_tdata,  // code_word
  input  logic                 s_axis_tlast,  // final_word
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*WORD_W-1:0]  m_axis_tdata,  // planes_01_word, planes_23_word
  output logic                 m_axis_tlast,  // last_of_item
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [WIDTH_W-1:0] image_width_q;
  logic [MASK_W-1:0]  rle_mask_q;
  logic               q_valid, q_pop;
  nrbp_entry_t        q_entry;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RLE_MASK) ? 32'(rle_mask_q) : 32'(image_width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= WIDTH_RESET;
      rle_mask_q    <= MASK_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        image_width_q <= pwdata[WIDTH_W-1:0];
      end else begin
        rle_mask_q <= pwdata[MASK_W-1:0];
      end
    end
  end

  nrbp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .rle_mask_i    (rle_mask_q),
    .q_valid_o     (q_valid),
    .q_entry_o     (q_entry),
    .q_pop_i       (q_pop)
  );

  nrbp_back #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .image_width_i (image_width_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- sv/nrbp_front.sv -----
// Front end: accepts code words, marks the nibbles that start a run and
// buffers them in a two-entry queue. Depends on nrbp_pkg.
module nrbp_front
  import nrbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [WORD_W-1:0]  s_axis_tdata,
  input  logic               s_axis_tlast,
  input  logic [MASK_W-1:0]  rle_mask_i,
  output logic               q_valid_o,
  output nrbp_entry_t        q_entry_o,
  input  logic               q_pop_i
);

  nrbp_entry_t       slot_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              push;
  nrbp_entry_t       entry;

  always_comb begin
    entry.code_word  = s_axis_tdata;
    entry.final_word = s_axis_tlast;
    for (int i = 0; i < NIBBLES; i++) begin
      entry.run_hit[i] = rle_mask_i[s_axis_tdata[4*i +: 4]];
    end
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (count_q != 2'd0);
  assign q_entry_o     = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !q_pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (!push && q_pop_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ----- sv/nrbp_back.sv -----
// Back end: decodes one queued word a nibble or a run copy per cycle unless
// a full output register stalls it, builds the bitplane groups and drives the output register. Depends on nrbp_pkg.
module nrbp_back
  import nrbp_pkg::*;
#(
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WIDTH_W-1:0]   image_width_i,
  input  logic                 q_valid_i,
  input  nrbp_entry_t          q_entry_i,
  output logic                 q_pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*WORD_W-1:0]  m_axis_tdata,
  output logic                 m_axis_tlast
);

  localparam int unsigned CMP_W = (COLUMN_BITS > WIDTH_W) ? COLUMN_BITS : WIDTH_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NIB, ST_RUN, ST_FINISH, ST_TAIL
  } state_e;

  state_e               state_q;
  nrbp_entry_t          item_q;
  logic [2:0]           idx_q;
  logic [3:0]           rem_q;
  logic [WORD_W-1:0]    acc01_q, acc23_q;
  logic [3:0]           bitpos_q;
  logic [COLUMN_BITS-1:0] col_q;
  logic                 runp_q;
  logic [3:0]           runpix_q;
  logic                 pend_valid_q;
  logic [WORD_W-1:0]    pend01_q, pend23_q;
  logic                 out_valid_q, out_last_q;
  logic [WORD_W-1:0]    out01_q, out23_q;

  logic [3:0]             nib, pix;
  logic                   do_place, fin_emit, emit_req, stall, out_free, push_out;
  logic                   full, row_end, place_emit, advance;
  logic [WORD_W-1:0]      set01, set23, grp01, grp23;
  logic [COLUMN_BITS-1:0] col_inc;

  always_comb begin
    nib      = item_q.code_word[{idx_q, 2'b00} +: 4];
    pix      = (state_q == ST_RUN || runp_q) ? runpix_q : nib;
    do_place = (state_q == ST_RUN) || ((state_q == ST_NIB) && (!runp_q || nib != 4'd0));
    fin_emit = (state_q == ST_FINISH) && item_q.final_word && (bitpos_q != 4'd0);

    set01 = acc01_q | (pix[0] ? (HI_SLOT >> bitpos_q) : '0)
                    | (pix[1] ? (LO_SLOT >> bitpos_q) : '0);
    set23 = acc23_q | (pix[2] ? (HI_SLOT >> bitpos_q) : '0)
                    | (pix[3] ? (LO_SLOT >> bitpos_q) : '0);
    col_inc    = col_q + 1'b1;
    row_end    = (image_width_i != '0) && (CMP_W'(col_inc) == CMP_W'(image_width_i));
    full       = (bitpos_q == 4'd15);
    place_emit = full || row_end;

    emit_req = (do_place && place_emit) || fin_emit;
    grp01    = do_place ? set01 : acc01_q;
    grp23    = do_place ? set23 : acc23_q;

    out_free = !out_valid_q || m_axis_tready;
    stall    = emit_req && pend_valid_q && !out_free;
    push_out = (emit_req && pend_valid_q && !stall) ||
               ((state_q == ST_TAIL) && pend_valid_q && out_free);
    q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

    advance = ((state_q == ST_NIB) && !(runp_q && nib > 4'd1)) ||
              ((state_q == ST_RUN) && (rem_q == 4'd1));
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out23_q, out01_q};
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      item_q       <= '0;
      idx_q        <= '0;
      rem_q        <= '0;
      acc01_q      <= '0;
      acc23_q      <= '0;
      bitpos_q     <= '0;
      col_q        <= '0;
      runp_q       <= 1'b0;
      runpix_q     <= '0;
      pend_valid_q <= 1'b0;
      pend01_q     <= '0;
      pend23_q     <= '0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out01_q      <= '0;
      out23_q      <= '0;
    end else begin
      if (push_out) begin
        out_valid_q <= 1'b1;
        out01_q     <= pend01_q;
        out23_q     <= pend23_q;
        out_last_q  <= (state_q == ST_TAIL);
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (emit_req && !stall) begin
        pend_valid_q <= 1'b1;
        pend01_q     <= grp01;
        pend23_q     <= grp23;
      end

      if (do_place && !stall) begin
        acc01_q  <= place_emit ? '0 : set01;
        acc23_q  <= place_emit ? '0 : set23;
        bitpos_q <= place_emit ? 4'd0 : bitpos_q + 4'd1;
        col_q    <= row_end ? '0 : col_inc;
      end

      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            item_q  <= q_entry_i;
            idx_q   <= '0;
            state_q <= ST_NIB;
          end
        end
        ST_NIB, ST_RUN: begin
          if (!stall) begin
            if (state_q == ST_NIB) begin
              if (runp_q) begin
                runp_q <= 1'b0;
                if (nib > 4'd1) begin
                  rem_q   <= nib - 4'd1;
                  state_q <= ST_RUN;
                end
              end else if (item_q.run_hit[idx_q]) begin
                runp_q   <= 1'b1;
                runpix_q <= nib;
              end
            end else begin
              rem_q <= rem_q - 4'd1;
            end
            if (advance) begin
              if (idx_q == 3'd7) begin
                state_q <= ST_FINISH;
              end else begin
                idx_q   <= idx_q + 3'd1;
                state_q <= ST_NIB;
              end
            end
          end
        end
        ST_FINISH: begin
          if (!stall) begin
            if (item_q.final_word) begin
              acc01_q  <= '0;
              acc23_q  <= '0;
              bitpos_q <= '0;
              col_q    <= '0;
              runp_q   <= 1'b0;
              runpix_q <= '0;
            end
            state_q <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> rem_q != 4'd0)
    else $error("run state entered with no copies left");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE) && q_valid_i)
    else $error("queue popped outside idle or while empty");

  a_empty_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bitpos_q == 4'd0 |-> (acc01_q == '0) && (acc23_q == '0))
    else $error("group holds pixels while slot pointer is at the left");

  a_tail_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAIL) && pend_valid_q && out_free |=> !pend_valid_q && out_last_q)
    else $error("pending group not flushed as last of item");
`endif

endmodule
